FILE: rtl/bhq_pkg.sv
package bhq_pkg;

   localparam int VALUE_W = 32;
   localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

endpackage

FILE: rtl/bhq_req_if.sv
interface bhq_req_if import bhq_pkg::*;;

   logic                      valid;
   logic                      ready;
   opcode_type                opcode;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);

endinterface

FILE: rtl/bhq_rsp_if.sv
interface bhq_rsp_if import bhq_pkg::*; #(parameter int CNT_W = 11);

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] removed_value;
   status_type                status;
   logic signed [VALUE_W-1:0] top_value;
   logic [CNT_W-1:0]          entry_total;
   logic                      is_empty;

   modport source (
      output valid, output removed_value, output status, output top_value,
      output entry_total, output is_empty, input ready
   );
   modport sink (
      input valid, input removed_value, input status, input top_value,
      input entry_total, input is_empty, output ready
   );

endinterface

FILE: rtl/bhq_cell.sv
module bhq_cell import bhq_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cell_ctrl_type             ctrl,
   input  logic signed [VALUE_W-1:0] value,
   input  logic                      left_ge,
   input  logic signed [VALUE_W-1:0] left_data,
   input  logic                      left_valid,
   input  logic signed [VALUE_W-1:0] right_data,
   input  logic                      right_valid,
   output logic                      ge,
   output logic signed [VALUE_W-1:0] data,
   output logic                      valid
);

   logic signed [VALUE_W-1:0] data_ff, data_in;
   logic                      valid_ff, valid_in;

   // entry stays in place on a push when it is at least the new value
   assign ge    = valid_ff && (data_ff >= value);
   assign data  = data_ff;
   assign valid = valid_ff;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.push && !ge) begin
         if (left_ge) begin
            data_in  = value;
            valid_in = 1'b1;
         end else begin
            data_in  = left_data;
            valid_in = left_valid;
         end
      end else if (ctrl.pop) begin
         data_in  = right_data;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: rtl/binary_max_heap_queue.sv
// Max priority queue of signed 32-bit values, up to CAPACITY entries. Storage is
// a row of CAPACITY cells kept sorted in descending order, cell 0 holding the
// maximum. A push is compared against every cell at once and each cell either
// holds, takes the new value or takes its left neighbor's entry; a pop shifts
// every cell one place toward cell 0. Each operation finishes in the cycle it is
// accepted and its response is registered, visible the following cycle; a new
// request is taken whenever the response register is empty or being drained, so
// the sustained rate is one item per cycle while responses keep being drained.
// No clearing pass is needed after reset. rsp_chan must be instantiated with
// CNT_W = $clog2(CAPACITY + 1).
module binary_max_heap_queue import bhq_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic       clock,
   input  logic       reset,
   bhq_req_if.sink    req_chan,
   bhq_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_removed_ff, rsp_removed_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_top_ff, rsp_top_in;

   logic signed [VALUE_W-1:0] cell_data  [CAPACITY];
   logic                      cell_valid [CAPACITY];
   logic                      cell_ge    [CAPACITY];

   logic          accept;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;

   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   assign ctrl.push = accept && (req_chan.opcode == OP_PUSH) && !full;
   assign ctrl.pop  = accept && (req_chan.opcode == OP_POP) && !empty;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      l_ge;
      logic signed [VALUE_W-1:0] l_data;
      logic                      l_valid;
      logic signed [VALUE_W-1:0] r_data;
      logic                      r_valid;

      if (i == 0) begin : g_head
         // head acts as if an infinite entry sat to its left
         assign l_ge    = 1'b1;
         assign l_data  = MOST_NEG;
         assign l_valid = 1'b0;
      end else begin : g_body
         assign l_ge    = cell_ge[i-1];
         assign l_data  = cell_data[i-1];
         assign l_valid = cell_valid[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign r_data  = MOST_NEG;
         assign r_valid = 1'b0;
      end else begin : g_link
         assign r_data  = cell_data[i+1];
         assign r_valid = cell_valid[i+1];
      end

      bhq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .value       (req_chan.value),
         .left_ge     (l_ge),
         .left_data   (l_data),
         .left_valid  (l_valid),
         .right_data  (r_data),
         .right_valid (r_valid),
         .ge          (cell_ge[i]),
         .data        (cell_data[i]),
         .valid       (cell_valid[i])
      );
   end

   always_comb begin
      count_in       = count_ff;
      rsp_removed_in = MOST_NEG;
      rsp_status_in  = ST_OK;
      rsp_top_in     = cell_valid[0] ? cell_data[0] : MOST_NEG;
      unique case (req_chan.opcode)
         OP_PUSH: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               count_in   = count_ff + CNT_W'(1);
               rsp_top_in = cell_ge[0] ? cell_data[0] : req_chan.value;
            end
         end
         OP_POP: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               count_in       = count_ff - CNT_W'(1);
               rsp_removed_in = cell_data[0];
               rsp_top_in     = cell_valid[1] ? cell_data[1] : MOST_NEG;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_removed_ff <= rsp_removed_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_top_ff     <= rsp_top_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.removed_value = rsp_removed_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.top_value     = rsp_top_ff;
   assign rsp_chan.entry_total   = count_ff;
   assign rsp_chan.is_empty      = empty;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == !empty)
      else $error("head cell valid disagrees with entry count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_valid[1] |-> (cell_valid[0] && cell_data[0] >= cell_data[1]))
      else $error("first two cells out of order");

   a_pop_max: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |=> (rsp_chan.removed_value == $past(cell_data[0])))
      else $error("pop did not return the maximum");

endmodule
